### src/kac_pkg.sv
// kac_pkg: shared types and constants for the keypad alarm controller
// holds the mode encoding, the controller state record and register reset values
// no dependencies
`timescale 1ns / 1ps

package kac_pkg;

    // operating modes, encoded as they appear on the mode output
    typedef enum logic [2:0] {
        MODE_DISARMED = 3'd0,
        MODE_ARMING   = 3'd1,
        MODE_ARMED    = 3'd2,
        MODE_MOTION   = 3'd3,
        MODE_ALARM    = 3'd4
    } mode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_PASSCODE    = 2'd0,
        REG_ARM_DELAY   = 2'd1,
        REG_ENTRY_DELAY = 2'd2,
        REG_MAX_WRONG   = 2'd3
    } cfg_reg_t;

    // field widths
    localparam int CODE_W  = 14;
    localparam int SECS_W  = 6;
    localparam int WRONG_W = 3;
    localparam int DIGIT_W = 4;
    localparam int CFG_W   = CODE_W;

    // reset values of the configuration registers
    localparam logic [CODE_W-1:0]  PASSCODE_RST    = CODE_W'(1234);
    localparam logic [SECS_W-1:0]  ARM_DELAY_RST   = SECS_W'(5);
    localparam logic [SECS_W-1:0]  ENTRY_DELAY_RST = SECS_W'(5);
    localparam logic [WRONG_W-1:0] MAX_WRONG_RST   = WRONG_W'(3);

    // default code length in digits
    localparam int CODE_DIGITS_DEF = 4;

    // largest valid key digit and wrong-attempt saturation value
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);
    localparam logic [WRONG_W-1:0] WRONG_SAT = WRONG_W'(7);

    // controller state apart from the digit counter
    typedef struct packed {
        mode_t                mode;
        logic [SECS_W-1:0]    countdown;
        logic [CODE_W-1:0]    code_accum;
        logic [WRONG_W-1:0]   wrong_attempts;
        logic                 motion_seen;
        logic                 grant_pending;
        logic                 buzzer_on;
    } ctrl_state_t;

    // configuration seen by the next-state logic
    typedef struct packed {
        logic [CODE_W-1:0]  passcode;
        logic [SECS_W-1:0]  arm_delay;
        logic [SECS_W-1:0]  entry_delay;
        logic [WRONG_W-1:0] max_wrong;
    } ctrl_cfg_t;

    // one input sample
    typedef struct packed {
        logic               second_tick;
        logic               motion;
        logic               key_valid;
        logic [DIGIT_W-1:0] key_digit;
        logic               green_button;
        logic               red_button;
    } sample_t;

endpackage

### src/kac_step.sv
// kac_step: next-state logic for one input sample of the alarm controller
// mode step, digit collection and code check, then the button wait
// depends on kac_pkg
`timescale 1ns / 1ps

module kac_step
    import kac_pkg::*;
#(
    parameter int CODE_DIGITS = CODE_DIGITS_DEF,
    parameter int DCNT_W      = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1
)
(
    input  ctrl_state_t       cur_state,
    input  logic [DCNT_W-1:0] cur_dcnt,
    input  ctrl_cfg_t         cfg,
    input  sample_t           smp,
    output ctrl_state_t       nxt_state,
    output logic [DCNT_W-1:0] nxt_dcnt
);

    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(CODE_DIGITS - 1);

    // mode change: clears code entry, loads countdown, alarm sets buzzer
    function automatic ctrl_state_t enter_mode(input ctrl_state_t s, input mode_t m,
                                               input ctrl_cfg_t c);
        ctrl_state_t r;
        r                = s;
        r.mode           = m;
        r.code_accum     = '0;
        r.wrong_attempts = '0;
        r.grant_pending  = 1'b0;
        if (m == MODE_ARMING)
        begin
            r.countdown = c.arm_delay;
        end
        else if (m == MODE_MOTION)
        begin
            r.countdown = c.entry_delay;
        end
        else if (m == MODE_ALARM)
        begin
            r.buzzer_on = 1'b1;
        end
        return r;
    endfunction

    ctrl_state_t         st;
    logic [DCNT_W-1:0]   dc;
    logic [SECS_W-1:0]   cd_dec;
    logic [CODE_W-1:0]   acc;
    logic                expired;

    always_comb
    begin
        st      = cur_state;
        dc      = cur_dcnt;
        acc     = '0;
        cd_dec  = (cur_state.countdown != '0) ? cur_state.countdown - SECS_W'(1) : '0;
        expired = (cd_dec == '0);

        if (!cur_state.grant_pending)
        begin
            // mode step: countdowns, motion edge, wrong-code limit
            case (cur_state.mode)
                MODE_ARMING:
                begin
                    if (smp.second_tick)
                    begin
                        st.countdown = cd_dec;
                        if (expired)
                        begin
                            st = enter_mode(st, MODE_ARMED, cfg);
                            dc = '0;
                        end
                    end
                end
                MODE_ARMED:
                begin
                    if (smp.motion)
                    begin
                        if (!cur_state.motion_seen)
                        begin
                            st.motion_seen = 1'b1;
                            st = enter_mode(st, MODE_MOTION, cfg);
                            dc = '0;
                        end
                    end
                    else
                    begin
                        st.motion_seen = 1'b0;
                    end
                end
                MODE_MOTION:
                begin
                    if (smp.second_tick)
                    begin
                        st.countdown = cd_dec;
                    end
                    if ((smp.second_tick && expired) ||
                        (cur_state.wrong_attempts >= cfg.max_wrong))
                    begin
                        st = enter_mode(st, MODE_ALARM, cfg);
                        dc = '0;
                    end
                end
                default:
                begin
                end
            endcase

            // digit collection and code check
            if (smp.key_valid && (smp.key_digit <= DIGIT_MAX))
            begin
                acc = (st.code_accum << 3) + (st.code_accum << 1)
                    + CODE_W'(smp.key_digit);
                if (dc == DCNT_LAST)
                begin
                    dc            = '0;
                    st.code_accum = '0;
                    if (acc == cfg.passcode)
                    begin
                        if (st.mode != MODE_ARMING)
                        begin
                            st.grant_pending = 1'b1;
                        end
                    end
                    else if ((st.mode == MODE_MOTION) && (st.wrong_attempts != WRONG_SAT))
                    begin
                        st.wrong_attempts = st.wrong_attempts + WRONG_W'(1);
                    end
                end
                else
                begin
                    dc            = dc + DCNT_W'(1);
                    st.code_accum = acc;
                end
            end
        end

        // button wait after an accepted code
        if (st.grant_pending)
        begin
            case (st.mode)
                MODE_ARMED:
                begin
                    if (smp.green_button)
                    begin
                        st = enter_mode(st, MODE_DISARMED, cfg);
                        dc = '0;
                    end
                end
                MODE_MOTION, MODE_ALARM:
                begin
                    if (smp.green_button)
                    begin
                        st.motion_seen = 1'b0;
                        st.buzzer_on   = 1'b0;
                        st = enter_mode(st, MODE_DISARMED, cfg);
                        dc = '0;
                    end
                end
                default:
                begin
                    if (smp.red_button)
                    begin
                        st = enter_mode(st, MODE_ARMING, cfg);
                        dc = '0;
                    end
                end
            endcase
        end

        nxt_state = st;
        nxt_dcnt  = dc;
    end

endmodule

### src/keypad_alarm_controller.sv
// keypad_alarm_controller: keypad security alarm controller, top level
// a result beat is valid in the cycle after its input beat is accepted
// throughput: one input beat per cycle while results are read; the result register frees as it is read
// the state update for a sample is one pass of next-state logic into the state registers
// reset: mode disarmed, all counters and flags clear, no result held,
// configuration registers back to passcode 1234, delays 5 s, wrong limit 3
`timescale 1ns / 1ps

module keypad_alarm_controller
    import kac_pkg::*;
#(
    parameter int CODE_DIGITS = CODE_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               second_tick,
    input  logic               motion,
    input  logic               key_valid,
    input  logic [DIGIT_W-1:0] key_digit,
    input  logic               green_button,
    input  logic               red_button,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         mode,
    output logic               buzzer,
    output logic [SECS_W-1:0]  seconds_left,
    output logic [1:0]         digits_entered,
    output logic               awaiting_button,
    output logic [WRONG_W-1:0] wrong_count
);

    localparam int DCNT_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

    ctrl_cfg_t         cfg_reg;
    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [DCNT_W-1:0] dcnt_next;
    sample_t           smp;
    logic              in_fire;

    logic               out_valid_reg;
    logic [2:0]         mode_out_reg;
    logic               buzzer_out_reg;
    logic [SECS_W-1:0]  secs_out_reg;
    logic [1:0]         digits_out_reg;
    logic               await_out_reg;
    logic [WRONG_W-1:0] wrong_out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.passcode    <= PASSCODE_RST;
            cfg_reg.arm_delay   <= ARM_DELAY_RST;
            cfg_reg.entry_delay <= ENTRY_DELAY_RST;
            cfg_reg.max_wrong   <= MAX_WRONG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PASSCODE:    cfg_reg.passcode    <= cfg_data;
                REG_ARM_DELAY:   cfg_reg.arm_delay   <= cfg_data[SECS_W-1:0];
                REG_ENTRY_DELAY: cfg_reg.entry_delay <= cfg_data[SECS_W-1:0];
                REG_MAX_WRONG:   cfg_reg.max_wrong   <= cfg_data[WRONG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input beat handshake: take a sample whenever the result register can move
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign smp.second_tick  = second_tick;
    assign smp.motion       = motion;
    assign smp.key_valid    = key_valid;
    assign smp.key_digit    = key_digit;
    assign smp.green_button = green_button;
    assign smp.red_button   = red_button;

    // next-state logic
    kac_step #(
        .CODE_DIGITS (CODE_DIGITS),
        .DCNT_W      (DCNT_W)
    ) u_step (
        .cur_state (state_reg),
        .cur_dcnt  (dcnt_reg),
        .cfg       (cfg_reg),
        .smp       (smp),
        .nxt_state (state_next),
        .nxt_dcnt  (dcnt_next)
    );

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode           <= MODE_DISARMED;
            state_reg.countdown      <= '0;
            state_reg.code_accum     <= '0;
            state_reg.wrong_attempts <= '0;
            state_reg.motion_seen    <= 1'b0;
            state_reg.grant_pending  <= 1'b0;
            state_reg.buzzer_on      <= 1'b0;
            dcnt_reg                 <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with the updated state
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_out_reg   <= state_next.mode;
            buzzer_out_reg <= state_next.buzzer_on;
            secs_out_reg   <= ((state_next.mode == MODE_ARMING) ||
                               (state_next.mode == MODE_MOTION)) ? state_next.countdown : '0;
            digits_out_reg <= 2'(dcnt_next);
            await_out_reg  <= state_next.grant_pending;
            wrong_out_reg  <= state_next.wrong_attempts;
        end
    end

    assign out_valid       = out_valid_reg;
    assign mode            = mode_out_reg;
    assign buzzer          = buzzer_out_reg;
    assign seconds_left    = secs_out_reg;
    assign digits_entered  = digits_out_reg;
    assign awaiting_button = await_out_reg;
    assign wrong_count     = wrong_out_reg;

endmodule

### tb/keypad_alarm_controller_tb.sv
// keypad_alarm_controller_tb: self-checking bench for the keypad alarm controller
// drives sample beats and register writes and checks each status beat against a predictor
// depends on kac_pkg and keypad_alarm_controller
`timescale 1ns / 1ps

module keypad_alarm_controller_tb;
    import kac_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 400000;

    // one status beat as seen on the result channel
    typedef struct packed {
        logic [2:0]         mode;
        logic               buzzer;
        logic [SECS_W-1:0]  seconds_left;
        logic [1:0]         digits_entered;
        logic               awaiting_button;
        logic [WRONG_W-1:0] wrong_count;
    } alarm_status_t;

    // alarm state predictor and queue of expected status beats
    class alarm_status_tracker;
        ctrl_cfg_t     cfg;
        ctrl_state_t   st;
        int            digit_count;
        alarm_status_t expected_status[$];
        int            error_count;

        function new();
            cfg.passcode    = PASSCODE_RST;
            cfg.arm_delay   = ARM_DELAY_RST;
            cfg.entry_delay = ENTRY_DELAY_RST;
            cfg.max_wrong   = MAX_WRONG_RST;
            st              = '0;
            st.mode         = MODE_DISARMED;
            digit_count     = 0;
            error_count     = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_PASSCODE:    cfg.passcode    = value;
                REG_ARM_DELAY:   cfg.arm_delay   = value[SECS_W-1:0];
                REG_ENTRY_DELAY: cfg.entry_delay = value[SECS_W-1:0];
                REG_MAX_WRONG:   cfg.max_wrong   = value[WRONG_W-1:0];
                default: ;
            endcase
        endfunction

        // any mode change drops the code in progress and the button wait
        function void enter_mode(mode_t m);
            st.mode           = m;
            digit_count       = 0;
            st.code_accum     = '0;
            st.wrong_attempts = '0;
            st.grant_pending  = 1'b0;
            if (m == MODE_ARMING)
                st.countdown = cfg.arm_delay;
            else if (m == MODE_MOTION)
                st.countdown = cfg.entry_delay;
            else if (m == MODE_ALARM)
                st.buzzer_on = 1'b1;
        endfunction

        // one second off the countdown, saturating; true when it reaches zero
        function bit tick_expires();
            if (st.countdown != '0)
                st.countdown = st.countdown - 1'b1;
            return st.countdown == '0;
        endfunction

        function void note_sample(sample_t s);
            int            acc;
            bit            match;
            alarm_status_t want;
            if (!st.grant_pending)
            begin
                // mode step
                case (st.mode)
                    MODE_ARMING:
                    begin
                        if (s.second_tick)
                        begin
                            if (tick_expires())
                                enter_mode(MODE_ARMED);
                        end
                    end
                    MODE_ARMED:
                    begin
                        if (s.motion)
                        begin
                            if (!st.motion_seen)
                            begin
                                st.motion_seen = 1'b1;
                                enter_mode(MODE_MOTION);
                            end
                        end
                        else
                            st.motion_seen = 1'b0;
                    end
                    MODE_MOTION:
                    begin
                        if (s.second_tick && tick_expires())
                            enter_mode(MODE_ALARM);
                        else if (st.wrong_attempts >= cfg.max_wrong)
                            enter_mode(MODE_ALARM);
                    end
                    default: ;
                endcase

                // digit collection and code compare
                if (s.key_valid && s.key_digit <= DIGIT_MAX)
                begin
                    acc           = int'(st.code_accum) * 10 + int'(s.key_digit);
                    st.code_accum = CODE_W'(acc);
                    digit_count++;
                    if (digit_count >= CODE_DIGITS_DEF)
                    begin
                        match         = (st.code_accum == cfg.passcode);
                        digit_count   = 0;
                        st.code_accum = '0;
                        if (match)
                        begin
                            if (st.mode != MODE_ARMING)
                                st.grant_pending = 1'b1;
                        end
                        else if (st.mode == MODE_MOTION && st.wrong_attempts < WRONG_SAT)
                            st.wrong_attempts = st.wrong_attempts + 1'b1;
                    end
                end
            end

            // button wait, also seen in the beat that accepts the code
            if (st.grant_pending)
            begin
                if (st.mode == MODE_ARMED)
                begin
                    if (s.green_button)
                        enter_mode(MODE_DISARMED);
                end
                else if (st.mode == MODE_MOTION || st.mode == MODE_ALARM)
                begin
                    if (s.green_button)
                    begin
                        st.motion_seen = 1'b0;
                        st.buzzer_on   = 1'b0;
                        enter_mode(MODE_DISARMED);
                    end
                end
                else if (s.red_button)
                    enter_mode(MODE_ARMING);
            end

            want.mode            = st.mode;
            want.buzzer          = st.buzzer_on;
            want.seconds_left    = (st.mode == MODE_ARMING || st.mode == MODE_MOTION) ?
                                   st.countdown : '0;
            want.digits_entered  = 2'(digit_count);
            want.awaiting_button = st.grant_pending;
            want.wrong_count     = st.wrong_attempts;
            expected_status.push_back(want);
        endfunction

        function void check_status(alarm_status_t got);
            alarm_status_t want;
            if (expected_status.size() == 0)
            begin
                $error("status beat with no sample pending");
                error_count++;
                return;
            end
            want = expected_status.pop_front();
            if (got.mode !== want.mode)
            begin
                $error("mode: expected %0d, got %0d", want.mode, got.mode);
                error_count++;
            end
            if (got.buzzer !== want.buzzer)
            begin
                $error("buzzer: expected %0d, got %0d", want.buzzer, got.buzzer);
                error_count++;
            end
            if (got.seconds_left !== want.seconds_left)
            begin
                $error("seconds_left: expected %0d, got %0d", want.seconds_left,
                       got.seconds_left);
                error_count++;
            end
            if (got.digits_entered !== want.digits_entered)
            begin
                $error("digits_entered: expected %0d, got %0d", want.digits_entered,
                       got.digits_entered);
                error_count++;
            end
            if (got.awaiting_button !== want.awaiting_button)
            begin
                $error("awaiting_button: expected %0d, got %0d", want.awaiting_button,
                       got.awaiting_button);
                error_count++;
            end
            if (got.wrong_count !== want.wrong_count)
            begin
                $error("wrong_count: expected %0d, got %0d", want.wrong_count,
                       got.wrong_count);
                error_count++;
            end
        endfunction
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [1:0]         cfg_index    = '0;
    logic [CFG_W-1:0]   cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               second_tick  = 1'b0;
    logic               motion       = 1'b0;
    logic               key_valid    = 1'b0;
    logic [DIGIT_W-1:0] key_digit    = '0;
    logic               green_button = 1'b0;
    logic               red_button   = 1'b0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [2:0]         mode;
    logic               buzzer;
    logic [SECS_W-1:0]  seconds_left;
    logic [1:0]         digits_entered;
    logic               awaiting_button;
    logic [WRONG_W-1:0] wrong_count;

    alarm_status_tracker tracker;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  items_sent     = 0;
    int                  cycle_count    = 0;
    bit                  motion_level   = 1'b0;

    keypad_alarm_controller DUT (.*);

    always #CLK_HALF clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("keypad_alarm_controller_tb: errors");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);

    // check status beats, then note sample beats taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_status({mode, buzzer, seconds_left, digits_entered,
                                      awaiting_button, wrong_count});
            if (in_valid && in_ready)
                tracker.note_sample({second_tick, motion, key_valid, key_digit,
                                     green_button, red_button});
        end
    end

    function automatic sample_t make_sample(bit tick, bit mot, bit kv,
                                            logic [DIGIT_W-1:0] digit, bit green, bit red);
        sample_t s;
        s.second_tick  = tick;
        s.motion       = mot;
        s.key_valid    = kv;
        s.key_digit    = digit;
        s.green_button = green;
        s.red_button   = red;
        return s;
    endfunction

    // one sample beat, with random idle cycles ahead of it
    task automatic send_sample(input sample_t s);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        second_tick  <= s.second_tick;
        motion       <= s.motion;
        key_valid    <= s.key_valid;
        key_digit    <= s.key_digit;
        green_button <= s.green_button;
        red_button   <= s.red_button;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // let every status beat drain before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        tracker.set_reg(idx, value);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] code, input logic [SECS_W-1:0] arm,
                                input logic [SECS_W-1:0] entry,
                                input logic [WRONG_W-1:0] limit);
        write_reg(REG_PASSCODE, code);
        write_reg(REG_ARM_DELAY, CFG_W'(arm));
        write_reg(REG_ENTRY_DELAY, CFG_W'(entry));
        write_reg(REG_MAX_WRONG, CFG_W'(limit));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // four digits, the passcode or a random code; for the passcode often a button, on the last digit or after it
    task automatic type_code(input bit correct);
        int                 code;
        int                 digits [CODE_DIGITS_DEF];
        bit                 press;
        bit                 with_last;
        bit                 use_red;
        sample_t            s;
        code = correct ? int'(tracker.cfg.passcode) : int'($urandom_range(9999));
        for (int i = CODE_DIGITS_DEF - 1; i >= 0; i--)
        begin
            digits[i] = code % 10;
            code      = code / 10;
        end
        press     = correct && ($urandom_range(3) != 0);
        with_last = ($urandom_range(2) == 0);
        for (int i = 0; i < CODE_DIGITS_DEF; i++)
        begin
            s = make_sample($urandom_range(3) == 0, motion_level, 1'b1,
                            DIGIT_W'(digits[i]), 1'b0, 1'b0);
            // stray non-digit keys now and then
            if (!correct && $urandom_range(7) == 0)
                s.key_digit = DIGIT_W'($urandom_range(10, 15));
            if (i == CODE_DIGITS_DEF - 1 && press && with_last)
            begin
                use_red        = (tracker.st.mode == MODE_DISARMED) ^ ($urandom_range(4) == 0);
                s.red_button   = use_red;
                s.green_button = !use_red;
            end
            send_sample(s);
        end
        if (press && !with_last)
        begin
            use_red = (tracker.st.mode == MODE_DISARMED) ^ ($urandom_range(4) == 0);
            send_sample(make_sample(1'b0, motion_level, 1'b0, '0, !use_red, use_red));
        end
    endtask

    // mix of code entry, tick runs, motion edges, buttons and noise
    task automatic run_episodes(input int target);
        int pick;
        int n;
        bit use_red;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                type_code(1'b1);
            else if (pick < 45)
                type_code(1'b0);
            else if (pick < 65)
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(64) : $urandom_range(1, 12);
                repeat (n) send_sample(make_sample(1'b1, motion_level, 1'b0, '0, 1'b0, 1'b0));
            end
            else if (pick < 80)
            begin
                motion_level = !motion_level;
                repeat ($urandom_range(1, 3))
                    send_sample(make_sample($urandom_range(3) == 0, motion_level, 1'b0, '0,
                                            1'b0, 1'b0));
            end
            else if (pick < 90)
            begin
                use_red = 1'($urandom_range(1));
                repeat ($urandom_range(1, 2))
                    send_sample(make_sample(1'b0, motion_level, 1'b0, '0, !use_red, use_red));
            end
            else
                repeat ($urandom_range(1, 4))
                    send_sample(sample_t'(9'($urandom)));
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // non-digit key with every button and the sensor high: disarmed ignores it all
        send_sample(make_sample(1'b1, 1'b1, 1'b1, 4'd15, 1'b1, 1'b1));
        // right code with red on the last digit arms in the same beat
        send_sample(make_sample(1'b0, 1'b0, 1'b1, 4'd1, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b0, 1'b1, 4'd2, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b0, 1'b1, 4'd3, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b0, 1'b1, 4'd4, 1'b0, 1'b1));
        // right code while arming is dropped
        send_sample(make_sample(1'b0, 1'b0, 1'b1, 4'd1, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b0, 1'b1, 4'd2, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b0, 1'b1, 4'd3, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b0, 1'b1, 4'd4, 1'b0, 1'b0));
        // arm delay runs out
        repeat (5) send_sample(make_sample(1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0));
        // motion edge starts the entry countdown
        send_sample(make_sample(1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
        // one wrong code
        send_sample(make_sample(1'b0, 1'b1, 1'b1, 4'd9, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b1, 1'b1, 4'd9, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0));
        // right code raises the button wait
        send_sample(make_sample(1'b0, 1'b1, 1'b1, 4'd1, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b1, 1'b1, 4'd2, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b1, 1'b1, 4'd3, 1'b0, 1'b0));
        send_sample(make_sample(1'b0, 1'b1, 1'b1, 4'd4, 1'b0, 1'b0));
        // wait freezes tick, sensor and keys; red is the wrong button here
        send_sample(make_sample(1'b1, 1'b0, 1'b1, 4'd9, 1'b0, 1'b1));
        // green disarms
        send_sample(make_sample(1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b0));

        // random phases, each with its own register setting and idle pattern
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: write_config(CFG_W'(1234), SECS_W'(5), SECS_W'(5), WRONG_W'(3));
                1: write_config(CFG_W'(0), SECS_W'(1), SECS_W'(1), WRONG_W'(1));
                2: write_config(CFG_W'(9999), SECS_W'(60), SECS_W'(60), WRONG_W'(7));
                // out-of-range passcode can never match
                3: write_config(CFG_W'(16383), SECS_W'($urandom_range(1, 10)),
                                SECS_W'($urandom_range(1, 10)), WRONG_W'($urandom_range(1, 7)));
                // zero delays expire on the first tick, zero limit alarms at once
                4: write_config(CFG_W'($urandom_range(9999)), SECS_W'(0), SECS_W'(0),
                                WRONG_W'(0));
                6: write_config(CFG_W'($urandom_range(9999)), SECS_W'(63),
                                SECS_W'($urandom_range(1, 8)), WRONG_W'($urandom_range(7)));
                default: write_config(CFG_W'($urandom_range(9999)),
                                      SECS_W'($urandom_range(1, 8)),
                                      SECS_W'($urandom_range(1, 8)),
                                      WRONG_W'($urandom_range(1, 7)));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            run_episodes(items_sent + ITEMS_PER_PHASE);
        end

        settle();
        if (tracker.error_count == 0 && tracker.expected_status.size() == 0)
            $display("keypad_alarm_controller_tb: clean");
        else
            $display("keypad_alarm_controller_tb: errors");
        $finish;
    end

endmodule
